// ----- hdl/lfm_pkg.sv -----
// shared constants and mixing weight table for the ladder filter
package lfm_pkg;
	localparam int SampleWidthDef = 24;
	localparam int CoefFrac = 22;
	localparam int GainFrac = 18;
	localparam int CoefWidth = 23;
	localparam int ModeWidth = 4;
	localparam int WeightWidth = 5;
	localparam int GainReset = 262144;
	localparam int ModeReset = 4;

	typedef enum logic [2:0] {
		REG_MODE = 3'd0,
		REG_POLE = 3'd1,
		REG_ZERO = 3'd2,
		REG_FBK  = 3'd3,
		REG_GAIN = 3'd4
	} reg_idx_t;

	typedef logic signed [WeightWidth-1:0] weight_t;

	// weight of stage value j for the given mode
	function automatic weight_t mix_weight(input logic [ModeWidth-1:0] mode,
			input logic [2:0] j);
		logic [WeightWidth*5-1:0] row;
		case (mode)
			4'd0:  row = {5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd1};
			4'd1:  row = {5'sd0, 5'sd0, 5'sd0, 5'sd1, 5'sd0};
			4'd2:  row = {5'sd0, 5'sd0, 5'sd1, 5'sd0, 5'sd0};
			4'd3:  row = {5'sd0, 5'sd1, 5'sd0, 5'sd0, 5'sd0};
			4'd4:  row = {5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd0};
			4'd5:  row = {5'sd0, 5'sd0, 5'sd0, -5'sd1, 5'sd1};
			4'd6:  row = {5'sd0, 5'sd0, 5'sd1, -5'sd2, 5'sd1};
			4'd7:  row = {5'sd0, -5'sd1, 5'sd3, -5'sd3, 5'sd1};
			4'd8:  row = {5'sd1, -5'sd4, 5'sd6, -5'sd4, 5'sd1};
			4'd9:  row = {-5'sd4, 5'sd4, 5'sd0, 5'sd0, 5'sd0};
			4'd10: row = {5'sd4, -5'sd8, 5'sd4, 5'sd0, 5'sd0};
			4'd11: row = {-5'sd4, 5'sd12, -5'sd12, 5'sd4, 5'sd0};
			4'd12: row = {5'sd0, -5'sd3, 5'sd3, 5'sd0, 5'sd0};
			4'd13: row = {5'sd0, 5'sd3, -5'sd6, 5'sd3, 5'sd0};
			4'd14: row = {5'sd0, 5'sd0, -5'sd2, 5'sd2, 5'sd0};
			default: row = '0;
		endcase
		case (j)
			3'd0: mix_weight = row[4:0];
			3'd1: mix_weight = row[9:5];
			3'd2: mix_weight = row[14:10];
			3'd3: mix_weight = row[19:15];
			3'd4: mix_weight = row[24:20];
			default: mix_weight = '0;
		endcase
	endfunction
endpackage

// ----- hdl/lfm_div.sv -----
// restoring divider, one quotient bit per cycle, unsigned
module lfm_div import lfm_pkg::*; #(
	parameter int NumWidth = 48,
	parameter int DenWidth = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NumWidth-1:0] num,
	input  logic [DenWidth-1:0] den,
	output logic                done,
	output logic [NumWidth-1:0] quot
);
	localparam int CntWidth = $clog2(NumWidth + 1);

	logic [DenWidth:0]   rem_q;
	logic [NumWidth-1:0] q_q;
	logic [DenWidth-1:0] den_q;
	logic [CntWidth-1:0] cnt_q;
	logic                busy_q;
	logic [DenWidth:0]   trial;
	logic [DenWidth+1:0] diff;

	assign trial = {rem_q[DenWidth-1:0], q_q[NumWidth-1]};
	assign diff  = {1'b0, trial} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntWidth'(NumWidth);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntWidth'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DenWidth+1]) begin
				rem_q <= diff[DenWidth:0];
				q_q   <= {q_q[NumWidth-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[NumWidth-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
endmodule

// ----- hdl/ladder_filter_multimode.sv -----
// four-pole ladder filter with selectable response, shared multiplier datapath
//  channel | dir | handshake              | payload
//  s_axis  | in  | s_axis_tvalid/tready   | tdata=sample_in, tlast=last_in
//  m_axis  | out | m_axis_tvalid/tready   | tdata=sample_out, tlast=last_out
//  cfg     | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data
// an item runs through gain, feedback, squaring, the quotient divider,
// the coefficient products, the stage updates and the mix; all steps but
// the divider use the shared multiplier
// reset clears the five stage values and loads register defaults
// the input stalls until the previous result has been taken
module ladder_filter_multimode import lfm_pkg::*; #(
	parameter int SAMPLE_WIDTH = SampleWidthDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata, // sample_in
	input  logic                        s_axis_tlast,       // last_in
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata, // sample_out
	output logic                        m_axis_tlast,       // last_out
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [CoefWidth-1:0]        cfg_data
);
	localparam int SW = SAMPLE_WIDTH;
	localparam int FB = SW - 4;
	localparam int TW = SW + 4;
	localparam int BW = ((SW + 7) / 8) * 8;
	localparam int MW = (TW + 1 > 25) ? TW + 1 : 25;
	localparam int PW = (2 * MW > 64) ? 2 * MW : 64;
	localparam int NW = TW + FB;
	localparam int DW = 2 * TW;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_GAIN = 10'b0000000010,
		ST_FBK  = 10'b0000000100,
		ST_SQ   = 10'b0000001000,
		ST_DIV  = 10'b0000010000,
		ST_C0   = 10'b0000100000,
		ST_STG  = 10'b0001000000,
		ST_MIX  = 10'b0010000000,
		ST_OUT  = 10'b0100000000,
		ST_WAIT = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [ModeWidth-1:0]        mode_q;
	logic signed [CoefWidth-1:0] pole_q;
	logic [CoefWidth-1:0]        zero_q, fbk_q, gain_q;
	logic signed [TW-1:0] stg_q [5];
	logic signed [TW-1:0] old_q [5];
	logic signed [TW-1:0] x_q, u_q;
	logic signed [SW-1:0] in_q;
	logic signed [24:0] c0_q, c1_q;
	logic signed [PW-1:0] acc_q;
	logic [2:0] idx_q;
	logic [1:0] sub_q;
	logic       neg_q, last_q;
	logic [DW-1:0] sq_q;
	logic signed [SW-1:0] res_q;

	// shared multiplier
	logic signed [MW-1:0] ma;
	logic signed [MW-1:0] mb;
	logic signed [2*MW-1:0] prod_w;
	logic signed [PW-1:0] prod;
	assign prod_w = ma * mb;
	assign prod = PW'(prod_w);

	logic signed [SW-1:0] s_in;
	assign s_in = s_axis_tdata[SW-1:0];

	function automatic logic signed [TW-1:0] sat_t(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] hi, lo;
		hi = (PW'(1) <<< (TW - 1)) - 1;
		lo = -(PW'(1) <<< (TW - 1));
		if (v > hi) sat_t = hi[TW-1:0];
		else if (v < lo) sat_t = lo[TW-1:0];
		else sat_t = v[TW-1:0];
	endfunction

	function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
			input int n);
		rnd = (v + (PW'(1) <<< (n - 1))) >>> n;
	endfunction

	logic [TW-1:0] mag;
	assign mag = neg_q ? TW'(-u_q) : TW'(u_q);

	logic div_start, div_done;
	logic [NW-1:0] quot;
	logic [DW-1:0] den;
	logic [NW-1:0] num;
	assign den = sq_q + (DW'(1) << FB);
	assign num = (NW'(mag) << FB) + NW'(den >> 1);

	lfm_div #(.NumWidth(NW), .DenWidth(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num), .den(den), .done(div_done), .quot(quot)
	);

	logic signed [PW-1:0] opa;
	assign opa = (PW'(1) <<< CoefFrac) + PW'(pole_q);

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_GAIN: begin ma = MW'(in_q); mb = MW'($signed({1'b0, gain_q})); end
			ST_FBK:  begin ma = MW'(old_q[4]); mb = MW'($signed({1'b0, fbk_q})); end
			ST_SQ:   begin ma = MW'($signed({1'b0, mag})); mb = MW'($signed({1'b0, mag})); end
			ST_C0: begin
				ma = MW'(opa);
				mb = sub_q[0] ? MW'($signed({1'b0, zero_q}))
					: MW'((PW'(1) <<< CoefFrac) - PW'($signed({1'b0, zero_q})));
			end
			ST_STG: begin
				case (sub_q)
					2'd0: begin ma = MW'(c0_q); mb = MW'(stg_q[idx_q - 3'd1]); end
					2'd1: begin ma = MW'(c1_q); mb = MW'(old_q[idx_q - 3'd1]); end
					default: begin ma = MW'(pole_q); mb = MW'(old_q[idx_q]); end
				endcase
			end
			ST_MIX: begin ma = MW'(mix_weight(mode_q, idx_q)); mb = MW'(stg_q[idx_q]); end
			default: ;
		endcase
	end

	// divider starts once the squared term has been registered
	assign div_start = (state_q == ST_SQ) && sub_q[0];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !s_axis_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= ModeWidth'(ModeReset);
			pole_q  <= '0;
			zero_q  <= '0;
			fbk_q   <= '0;
			gain_q  <= CoefWidth'(GainReset);
			for (int i = 0; i < 5; i++) stg_q[i] <= '0;
			m_axis_tvalid <= 1'b0;
			idx_q <= '0;
			sub_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE: mode_q <= cfg_data[ModeWidth-1:0];
					REG_POLE: pole_q <= cfg_data;
					REG_ZERO: zero_q <= cfg_data;
					REG_FBK:  fbk_q  <= cfg_data;
					REG_GAIN: gain_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: if (s_axis_tvalid) state_q <= ST_GAIN;
				ST_GAIN: state_q <= ST_FBK;
				ST_FBK:  state_q <= ST_SQ;
				ST_SQ: begin
					if (sub_q[0]) begin
						state_q <= ST_DIV;
						sub_q <= '0;
					end else sub_q <= sub_q + 2'd1;
				end
				ST_DIV: if (div_done) begin
					stg_q[0] <= neg_q ? TW'(-quot) : TW'(quot);
					state_q <= ST_C0;
					sub_q <= '0;
				end
				ST_C0: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q[0]) begin
						state_q <= ST_STG;
						sub_q <= '0;
						idx_q <= 3'd1;
					end
				end
				ST_STG: begin
					if (sub_q == 2'd2) begin
						sub_q <= '0;
						stg_q[idx_q] <= sat_t(rnd(acc_q - prod, CoefFrac));
						if (idx_q == 3'd4) begin
							state_q <= ST_MIX;
							idx_q <= '0;
						end else idx_q <= idx_q + 3'd1;
					end else sub_q <= sub_q + 2'd1;
				end
				ST_MIX: begin
					if (idx_q == 3'd4) state_q <= ST_OUT;
					else idx_q <= idx_q + 3'd1;
				end
				ST_OUT: begin
					m_axis_tvalid <= 1'b1;
					state_q <= ST_WAIT;
				end
				ST_WAIT: if (m_axis_tready) begin
					m_axis_tvalid <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (s_axis_tvalid) begin
				last_q <= s_axis_tlast;
				in_q <= s_in;
				for (int i = 0; i < 5; i++) old_q[i] <= stg_q[i];
			end
			ST_GAIN: x_q <= sat_t(rnd(prod, GainFrac));
			ST_FBK: begin
				u_q <= sat_t(PW'(x_q) - rnd(prod, GainFrac));
				neg_q <= sat_t(PW'(x_q) - rnd(prod, GainFrac)) < 0;
			end
			ST_SQ: sq_q <= DW'(rnd(prod, FB));
			ST_C0: begin
				if (sub_q[0]) c1_q <= 25'(rnd(prod, CoefFrac));
				else c0_q <= 25'(rnd(prod, CoefFrac));
			end
			ST_STG: begin
				if (sub_q == 2'd0) acc_q <= prod;
				else if (sub_q == 2'd1) acc_q <= acc_q + prod;
			end
			ST_MIX: begin
				if (idx_q == 3'd0) acc_q <= prod;
				else acc_q <= acc_q + prod;
			end
			ST_OUT: begin
				if (acc_q > ((PW'(1) <<< (SW - 1)) - 1))
					res_q <= {1'b0, {(SW-1){1'b1}}};
				else if (acc_q < -(PW'(1) <<< (SW - 1)))
					res_q <= {1'b1, {(SW-1){1'b0}}};
				else res_q <= acc_q[SW-1:0];
			end
			default: ;
		endcase
	end

	assign m_axis_tdata = BW'($unsigned(res_q));
	assign m_axis_tlast = last_q;
endmodule

// ----- hdl/lfm_checker.sv -----
// port-level checks for the ladder filter, bound to the top level
module lfm_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic cfg_valid,
	input logic cfg_ready
);
	// no new item while a result waits
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input ready with result pending");
	// a result leaves only once, then the block goes back to idle
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid) else $error("result repeated");
	// an accepted item drops ready at once
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready after accept");
	// no config write while busy
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> s_axis_tready) else $error("config taken while busy");
endmodule

bind ladder_filter_multimode lfm_checker u_lfm_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

// ----- tb/sv/ladder_filter_multimode_tb.sv -----
// testbench for the multimode ladder filter: directed table, random phases, scoreboard
module ladder_filter_multimode_tb import lfm_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = 24;
	localparam int IdlePct = 36;
	localparam int WatchLimit = 20000;
	localparam logic [2:0] RegUnused = 3'd5;

	typedef struct packed {
		logic [SW-1:0] smp;
		logic          lst;
	} filt_item_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_SMP, ROW_SMP_CHK} row_kind_t;

	typedef struct {
		row_kind_t     kind;
		logic [2:0]    idx;
		logic [22:0]   val;
		logic [SW-1:0] smp;
		logic          lst;
		logic [SW-1:0] want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [SW-1:0] s_axis_tdata = '0; // sample_in
	logic s_axis_tlast = 1'b0;        // last_in
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [SW-1:0] m_axis_tdata;      // sample_out
	logic m_axis_tlast;               // last_out
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [CoefWidth-1:0] cfg_data = '0;

	ladder_filter_multimode u_top (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// filter state and registers as the predictor sees them
	longint ladder[5];
	logic [3:0] cur_mode;
	longint pole_a, zmix_b1, fbk_k, gain_g;
	filt_item_t expected_out[$];
	int errors = 0;
	int accepts = 0;
	bit calm = 1'b0;

	const int weights[16][5] = '{
		'{1, 0, 0, 0, 0}, '{0, 1, 0, 0, 0}, '{0, 0, 1, 0, 0}, '{0, 0, 0, 1, 0},
		'{0, 0, 0, 0, 1}, '{1, -1, 0, 0, 0}, '{1, -2, 1, 0, 0}, '{1, -3, 3, -1, 0},
		'{1, -4, 6, -4, 1}, '{0, 0, 0, 4, -4}, '{0, 0, 4, -8, 4}, '{0, 4, -12, 12, -4},
		'{0, 0, 3, -3, 0}, '{0, 3, -6, 3, 0}, '{0, 2, -2, 0, 0}, '{0, 0, 0, 0, 0}
	};

	function automatic longint clamp(longint v, int w);
		longint hi, lo;
		hi = (64'sd1 <<< (w - 1)) - 1;
		lo = -(64'sd1 <<< (w - 1));
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic longint rnd_shift(longint v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	// one sample through gain, feedback, squash, four stages and the mix
	function automatic logic [SW-1:0] ladder_sample(logic [SW-1:0] smp);
		longint prev[5];
		longint x, u, m, d, q, opa, c0, c1, acc, mix;
		prev = ladder;
		x = clamp(rnd_shift(gain_g * longint'($signed(smp)), GainFrac), SW + 4);
		u = clamp(x - rnd_shift(fbk_k * prev[4], GainFrac), SW + 4);
		m = u < 0 ? -u : u;
		d = (64'sd1 <<< (SW - 4)) + rnd_shift(m * m, SW - 4);
		q = ((m <<< (SW - 4)) + (d >>> 1)) / d;
		ladder[0] = u < 0 ? -q : q;
		opa = (64'sd1 <<< CoefFrac) + pole_a;
		c0 = rnd_shift(opa * ((64'sd1 <<< CoefFrac) - zmix_b1), CoefFrac);
		c1 = rnd_shift(opa * zmix_b1, CoefFrac);
		for (int i = 1; i < 5; i++) begin
			acc = c0 * ladder[i-1] + c1 * prev[i-1] - pole_a * prev[i];
			ladder[i] = clamp(rnd_shift(acc, CoefFrac), SW + 4);
		end
		mix = 0;
		for (int i = 0; i < 5; i++)
			mix += weights[cur_mode][i] * ladder[i];
		return SW'(clamp(mix, SW));
	endfunction

	task automatic idle_gap();
		while (!calm && $urandom_range(99) < IdlePct)
			@(negedge clk);
	endtask

	task automatic wait_drained();
		while (expected_out.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [22:0] val);
		@(negedge clk);
		idle_gap();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		#1;
		while (!cfg_ready) begin
			@(negedge clk);
			#1;
		end
		@(posedge clk);
		accepts++;
		case (idx)
			REG_MODE: cur_mode = val[3:0];
			REG_POLE: pole_a = longint'($signed(val));
			REG_ZERO: zmix_b1 = longint'(val);
			REG_FBK:  fbk_k = longint'(val);
			REG_GAIN: gain_g = longint'(val);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drives one sample; keeps valid high into the next item when no gap follows
	task automatic send_sample(logic [SW-1:0] smp, logic lst);
		filt_item_t it;
		@(negedge clk);
		if (!calm && $urandom_range(99) < IdlePct) begin
			s_axis_tvalid <= 1'b0;
			idle_gap();
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		s_axis_tlast  <= lst;
		#1;
		while (!s_axis_tready) begin
			@(negedge clk);
			#1;
		end
		@(posedge clk);
		accepts++;
		it.smp = ladder_sample(smp);
		it.lst = lst;
		expected_out.push_back(it);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	// result side: ready decided at the falling edge, item taken at the rising edge
	always begin
		filt_item_t got, want;
		@(negedge clk);
		m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
		#1;
		if (m_axis_tvalid && m_axis_tready) begin
			got.smp = m_axis_tdata;
			got.lst = m_axis_tlast;
			@(posedge clk);
			accepts++;
			if (expected_out.size() == 0) begin
				$display("%0t: result with nothing expected: sample %h last %b",
					$time, got.smp, got.lst);
				errors++;
			end else begin
				want = expected_out.pop_front();
				if (got.smp !== want.smp) begin
					$display("%0t: sample_out expected %h actual %h",
						$time, want.smp, got.smp);
					errors++;
				end
				if (got.lst !== want.lst) begin
					$display("%0t: last_out expected %b actual %b",
						$time, want.lst, got.lst);
					errors++;
				end
			end
		end
	end

	// ends the run if nothing moves for too long
	always begin
		int quiet, seen;
		quiet = 0;
		seen = 0;
		forever begin
			@(posedge clk);
			if (accepts != seen) begin
				seen = accepts;
				quiet = 0;
			end else if (arst_n) begin
				quiet++;
				if (quiet >= WatchLimit) begin
					$display("ladder_filter_multimode_tb: errors");
					$finish;
				end
			end
		end
	end

	function automatic logic [22:0] pick_reg(logic [22:0] lo, logic [22:0] hi, bit sgn);
		int r;
		r = $urandom_range(7);
		if (r == 0) return lo;
		if (r == 1) return hi;
		if (sgn) return 23'($urandom);
		return 23'($urandom_range(hi, lo));
	endfunction

	function automatic logic [SW-1:0] pick_sample();
		case ($urandom_range(5))
			0: return SW'($urandom_range(1, 0) ? 24'h7fffff : 24'h800000);
			1, 2: return SW'($signed(14'($urandom)));
			default: return SW'($urandom);
		endcase
	endfunction

	row_t dir_rows[] = '{
		'{ROW_SMP_CHK, 3'd0, 23'd0, 24'h000000, 1'b0, 24'h000000},
		'{ROW_SMP, 3'd0, 23'd0, 24'h7fffff, 1'b0, 24'h0},
		'{ROW_SMP, 3'd0, 23'd0, 24'h800000, 1'b1, 24'h0},
		'{ROW_SMP, 3'd0, 23'd0, 24'h000001, 1'b0, 24'h0},
		'{ROW_SMP, 3'd0, 23'd0, 24'hffffff, 1'b1, 24'h0},
		'{ROW_CFG, REG_MODE, 23'd15, 24'h0, 1'b0, 24'h0},
		'{ROW_SMP_CHK, 3'd0, 23'd0, 24'h7fffff, 1'b1, 24'h000000},
		'{ROW_SMP_CHK, 3'd0, 23'd0, 24'h800000, 1'b0, 24'h000000},
		'{ROW_CFG, REG_MODE, 23'd0, 24'h0, 1'b0, 24'h0},
		'{ROW_CFG, REG_GAIN, 23'h7fffff, 24'h0, 1'b0, 24'h0},
		'{ROW_SMP, 3'd0, 23'd0, 24'h7fffff, 1'b0, 24'h0},
		'{ROW_SMP, 3'd0, 23'd0, 24'h800000, 1'b1, 24'h0},
		'{ROW_CFG, REG_POLE, 23'h400000, 24'h0, 1'b0, 24'h0},
		'{ROW_CFG, REG_ZERO, 23'h400000, 24'h0, 1'b0, 24'h0},
		'{ROW_CFG, REG_FBK, 23'h7fffff, 24'h0, 1'b0, 24'h0},
		'{ROW_CFG, REG_MODE, 23'd8, 24'h0, 1'b0, 24'h0},
		'{ROW_SMP, 3'd0, 23'd0, 24'h7fffff, 1'b0, 24'h0},
		'{ROW_SMP, 3'd0, 23'd0, 24'h555555, 1'b1, 24'h0},
		'{ROW_CFG, REG_POLE, 23'h3fffff, 24'h0, 1'b0, 24'h0},
		'{ROW_CFG, REG_ZERO, 23'h7fffff, 24'h0, 1'b0, 24'h0},
		'{ROW_CFG, RegUnused, 23'h7fffff, 24'h0, 1'b0, 24'h0},
		'{ROW_CFG, REG_GAIN, 23'd0, 24'h0, 1'b0, 24'h0},
		'{ROW_SMP, 3'd0, 23'd0, 24'haaaaaa, 1'b0, 24'h0},
		'{ROW_SMP, 3'd0, 23'd0, 24'h7fffff, 1'b1, 24'h0}
	};

	initial begin
		for (int i = 0; i < 5; i++)
			ladder[i] = 0;
		cur_mode = 4'(ModeReset);
		pole_a = 0;
		zmix_b1 = 0;
		fbk_k = 0;
		gain_g = GainReset;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				stop_sending();
				wait_drained();
				write_reg(dir_rows[r].idx, dir_rows[r].val);
			end else begin
				send_sample(dir_rows[r].smp, dir_rows[r].lst);
				// typed-in values override the predictor where they are obvious
				if (dir_rows[r].kind == ROW_SMP_CHK)
					expected_out[$].smp = dir_rows[r].want;
			end
		end

		for (int ph = 0; ph < 20; ph++) begin
			stop_sending();
			wait_drained();
			calm = (ph >= 6 && ph < 9);
			write_reg(REG_MODE, 23'(ph < 16 ? ph : $urandom_range(15)));
			write_reg(REG_POLE, pick_reg(23'h400000, 23'h3fffff, 1'b1));
			write_reg(REG_ZERO, pick_reg(23'd0, 23'h400000, 1'b0));
			write_reg(REG_FBK, pick_reg(23'd0, 23'h7fffff, 1'b0));
			write_reg(REG_GAIN, pick_reg(23'd0, 23'h7fffff, 1'b0));
			if ($urandom_range(3) == 0)
				write_reg(3'($urandom_range(7, 5)), 23'($urandom));
			for (int n = 0; n < 100; n++)
				send_sample(pick_sample(), 1'($urandom_range(1)));
		end
		stop_sending();
		calm = 1'b0;

		while (expected_out.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("ladder_filter_multimode_tb: clean");
		else
			$display("ladder_filter_multimode_tb: errors");
		$finish;
	end
endmodule

// ----- files.f -----
hdl/lfm_pkg.sv
hdl/lfm_div.sv
hdl/ladder_filter_multimode.sv
hdl/lfm_checker.sv
tb/sv/ladder_filter_multimode_tb.sv
